FILE: design/rsame_pkg.sv
// rsame_pkg: shared constants for the modular exponentiation block.
// Configuration register indexes, index width and byte width. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsame_pkg;

	// configuration register index
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_KEY_EXPONENT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MODULUS      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BYTE_OUTPUT  = 2'd2;

	// low byte kept in byte mode
	localparam int unsigned BYTE_BITS = 8;

endpackage

`default_nettype wire

FILE: design/rsame_mulmod.sv
// rsame_mulmod: interleaved (MSB-first) modular multiplier, one bit of b per cycle.
// Self-contained; used by rsa_modular_exponentiation.
`timescale 1ns / 1ps
`default_nettype none

module rsame_mulmod #(
	parameter int unsigned W = 31
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] opa,
	input  wire logic [W-1:0] opb,
	input  wire logic [W-1:0] modulus,
	output logic              done,
	output logic [W-1:0]      product
);

	localparam int unsigned CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     acc_q;

	logic [W:0]   dbl;
	logic [W:0]   mod_x;
	logic [W-1:0] dbl_r;
	logic [W:0]   sum;
	logic [W-1:0] sum_r;
	logic [W-1:0] acc_d;

	// acc = 2*acc mod m, then + a mod m when the current bit of b is set
	always_comb begin
		mod_x = {1'b0, modulus};
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= mod_x) ? W'(dbl - mod_x) : W'(dbl);
		sum   = {1'b0, dbl_r} + {1'b0, a_q};
		sum_r = (sum >= mod_x) ? W'(sum - mod_x) : W'(sum);
		acc_d = b_q[W-1] ? sum_r : dbl_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= opa;
			b_q   <= opb;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_d;
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

FILE: design/rsa_modular_exponentiation.sv
// rsa_modular_exponentiation: top level, config registers, square-and-multiply sequencer.
// Depends on rsame_pkg and rsame_mulmod.
//
// Raises each input word to key_exponent modulo modulus (right-to-left
// square-and-multiply) and returns one output word per input word. The input
// is first reduced mod modulus on the same multiplier (as 1 * value), and the
// running result starts at 1 mod modulus, so exponent 0 gives 1 (or 0 when
// the modulus is 1). All products go through one interleaved modular
// multiplier. Per word: the reduction, then for each exponent bit up to the
// highest set one, the sequencer picks the next operation in S_NEXT and runs
// a square, plus a multiply before it for a set bit; the square after the top
// set bit is skipped. S_FIN then hands the word to the output register.
// A zero modulus goes straight from S_IDLE to S_FIN, with value_out 0 and
// zero_modulus set. in_stall is high while a word is in flight; the result
// sits in an output register, so a stalled output does not hold the next
// word's computation, only its hand-off. Byte mode keeps the low 8 bits.
// Configuration writes must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rsa_modular_exponentiation
	import rsame_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = 31
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration write port
	input  wire logic                     cfg_we,
	input  wire logic [REG_IDX_W-1:0]     cfg_index,
	input  wire logic [OPERAND_WIDTH-1:0] cfg_data,
	// input words
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [OPERAND_WIDTH-1:0] value_in,
	// output words
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [OPERAND_WIDTH-1:0]      value_out,
	output logic                          zero_modulus
);

	localparam int unsigned W = OPERAND_WIDTH;
	localparam logic [W-1:0] BYTE_MASK = W'((1 << BYTE_BITS) - 1);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REDUCE = 3'd1;
	localparam logic [2:0] S_NEXT   = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_SQR    = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	// configuration registers
	logic [W-1:0] key_exponent_q;
	logic [W-1:0] modulus_q;
	logic         byte_output_q;

	// working registers
	logic [2:0]   state_q;
	logic [W-1:0] acc_q;     // running result
	logic [W-1:0] sq_q;      // base^(2^i) mod m
	logic [W-1:0] exp_q;     // exponent, consumed LSB first
	logic         zmod_q;

	// output register
	logic         out_valid_q;
	logic [W-1:0] value_out_q;
	logic         zmod_out_q;

	// shared multiplier
	logic         mul_start;
	logic [W-1:0] mul_a;
	logic [W-1:0] mul_b;
	logic         mul_done;
	logic [W-1:0] mul_p;

	logic in_take;
	logic out_free;
	logic exp_last;   // no set bits above the current one
	logic [W-1:0] result;

	assign in_take  = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign exp_last = (exp_q >> 1) == '0;

	always_comb begin
		result = zmod_q ? '0 : (byte_output_q ? (acc_q & BYTE_MASK) : acc_q);
	end

	// operand selection and start for the shared multiplier
	always_comb begin
		mul_start = 1'b0;
		mul_a     = sq_q;
		mul_b     = sq_q;
		unique case (state_q)
			S_IDLE: begin
				// reduction: 1 * value mod m
				mul_start = in_take && (modulus_q != '0);
				mul_a     = W'(1);
				mul_b     = value_in;
			end
			S_NEXT: begin
				if (exp_q != '0) begin
					mul_start = 1'b1;
					if (exp_q[0]) begin
						mul_a = acc_q;
					end
				end
			end
			S_MUL: begin
				mul_start = mul_done && !exp_last;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	rsame_mulmod #(
		.W(W)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.opa     (mul_a),
		.opb     (mul_b),
		.modulus (modulus_q),
		.done    (mul_done),
		.product (mul_p)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_exponent_q <= '0;
			modulus_q      <= '0;
			byte_output_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_EXPONENT: key_exponent_q <= cfg_data;
				REG_MODULUS:      modulus_q      <= cfg_data;
				REG_BYTE_OUTPUT:  byte_output_q  <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load on hand-off, clear once taken
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= (modulus_q == '0) ? S_FIN : S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (mul_done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (exp_q == '0) begin
						state_q <= S_FIN;
					end else if (exp_q[0]) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= exp_last ? S_FIN : S_SQR;
					end
				end
				S_SQR: begin
					if (mul_done) begin
						state_q <= S_NEXT;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			zmod_q <= (modulus_q == '0);
			acc_q  <= (modulus_q == W'(1)) ? '0 : W'(1);
			exp_q  <= key_exponent_q;
		end
		if (mul_done) begin
			if (state_q == S_MUL) begin
				acc_q <= mul_p;
			end else begin
				sq_q <= mul_p;
			end
			if (state_q == S_SQR) begin
				exp_q <= exp_q >> 1;
			end
		end
		if ((state_q == S_FIN) && out_free) begin
			value_out_q <= result;
			zmod_out_q  <= zmod_q;
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign value_out    = value_out_q;
	assign zero_modulus = zmod_out_q;

endmodule

`default_nettype wire
